FILE: design/npsjf_pkg.sv
// Shared constants and types of the non-preemptive shortest-job-first scheduler.
package npsjf_pkg;

   localparam int MAX_JOBS    = 16;
   localparam int IDX_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W       = $clog2(MAX_JOBS + 1);
   localparam int IN_TIME_W   = 16;
   localparam int ENTRY_W     = 2 * IN_TIME_W;
   localparam int CLK_W       = $clog2((MAX_JOBS + 1) * (2 ** IN_TIME_W - 1) + 1);
   localparam int OUT_TIME_W  = 21;
   localparam int JOB_INDEX_W = 4;

   typedef enum logic [2:0] {
      ST_LOAD   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

endpackage

FILE: design/npsjf_req_if.sv
// Job transaction channel: one job with its arrival and burst times.
interface npsjf_req_if;
   import npsjf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [IN_TIME_W-1:0] arrival_time;
   logic [IN_TIME_W-1:0] burst_time;
   logic                 is_last;

   modport source (output valid, output arrival_time, output burst_time, output is_last,
                   input ready);
   modport sink   (input valid, input arrival_time, input burst_time, input is_last,
                   output ready);
endinterface

FILE: design/npsjf_rsp_if.sv
// Result transaction channel: one scheduled job with its timing figures.
interface npsjf_rsp_if;
   import npsjf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [JOB_INDEX_W-1:0] job_index;
   logic [OUT_TIME_W-1:0]  start_time;
   logic [OUT_TIME_W-1:0]  end_time;
   logic [OUT_TIME_W-1:0]  turnaround;
   logic [OUT_TIME_W-1:0]  waiting;
   logic                   overflow_flag;
   logic                   last_result;

   modport source (output valid, output job_index, output start_time, output end_time,
                   output turnaround, output waiting, output overflow_flag,
                   output last_result, input ready);
   modport sink   (input valid, input job_index, input start_time, input end_time,
                   input turnaround, input waiting, input overflow_flag,
                   input last_result, output ready);
endinterface

FILE: design/nonpreemptive_sjf_scheduler.sv
// Top level of the non-preemptive shortest-job-first scheduler.
// Jobs are loaded one transaction per cycle into a job memory of MAX_JOBS entries; jobs
// beyond that are dropped and flagged on every result of the set. The job that carries
// is_last starts scheduling, and no job is accepted until the last result of the set has
// been placed in the output register. Each scheduling decision sweeps the stored jobs one
// at a time through the registered memory read port and the arrival and burst compares;
// when no pending job has arrived yet, one extra sweep advances the clock to the earliest
// pending arrival. A result waiting in the output register does not stop the next sweep.
module nonpreemptive_sjf_scheduler (
   input  logic        clock,
   input  logic        reset,
   npsjf_req_if.sink   req_chan,
   npsjf_rsp_if.source rsp_chan
);
   import npsjf_pkg::*;

   logic [ENTRY_W-1:0] job_mem [MAX_JOBS];
   logic [ENTRY_W-1:0] mem_q_ff;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        job_count_ff, job_count_in;
   logic                    dropped_ff, dropped_in;
   logic [CLK_W-1:0]        clock_ff, clock_in;
   logic [MAX_JOBS-1:0]     done_ff, done_in;
   logic [CNT_W-1:0]        finished_ff, finished_in;
   logic [CNT_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    found_ff, found_in;
   logic                    pend_ff, pend_in;
   logic [IN_TIME_W-1:0]    best_burst_ff, best_burst_in;
   logic [IN_TIME_W-1:0]    best_arr_ff, best_arr_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [IN_TIME_W-1:0]    next_arr_ff, next_arr_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [JOB_INDEX_W-1:0]  rsp_index_ff;
   logic [OUT_TIME_W-1:0]   rsp_start_ff, rsp_end_ff, rsp_tat_ff, rsp_wait_ff;
   logic                    rsp_ovf_ff, rsp_last_ff;

   logic                    req_accept, mem_we, issue, rsp_free, emit, emit_last;
   logic                    cand_live, arrived;
   logic [IN_TIME_W-1:0]    q_arr, q_bur;
   logic [CLK_W-1:0]        end_full, tat_full, wait_full;

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign mem_we         = req_accept && (job_count_ff < CNT_W'(MAX_JOBS));
   assign issue          = (state_ff == ST_SCAN) && (scan_cnt_ff < job_count_ff);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign emit           = (state_ff == ST_DECIDE) && found_ff && rsp_free;
   assign emit_last      = emit && ((finished_ff + CNT_W'(1)) == job_count_ff);

   assign q_arr     = mem_q_ff[ENTRY_W-1:IN_TIME_W];
   assign q_bur     = mem_q_ff[IN_TIME_W-1:0];
   assign cand_live = rd_vld_ff && !done_ff[rd_idx_ff];
   assign arrived   = CLK_W'(q_arr) <= clock_ff;

   assign end_full  = clock_ff + CLK_W'(best_burst_ff);
   assign wait_full = clock_ff - CLK_W'(best_arr_ff);
   assign tat_full  = clock_ff + CLK_W'(best_burst_ff) - CLK_W'(best_arr_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         job_mem[job_count_ff[IDX_W-1:0]] <= {req_chan.arrival_time, req_chan.burst_time};
      end
      if (issue) begin
         mem_q_ff <= job_mem[scan_cnt_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in      = state_ff;
      job_count_in  = job_count_ff;
      dropped_in    = dropped_ff;
      clock_in      = clock_ff;
      done_in       = done_ff;
      finished_in   = finished_ff;
      scan_cnt_in   = scan_cnt_ff;
      found_in      = found_ff;
      pend_in       = pend_ff;
      best_burst_in = best_burst_ff;
      best_arr_in   = best_arr_ff;
      best_idx_in   = best_idx_ff;
      next_arr_in   = next_arr_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (mem_we) begin
                  job_count_in = job_count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_chan.is_last && (job_count_in != '0)) begin
                  state_in    = ST_SCAN;
                  scan_cnt_in = '0;
                  found_in    = 1'b0;
                  pend_in     = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
            if (cand_live) begin
               if (!pend_ff || (q_arr < next_arr_ff)) begin
                  next_arr_in = q_arr;
                  pend_in     = 1'b1;
               end
               if (arrived && (!found_ff || (q_bur < best_burst_ff))) begin
                  best_burst_in = q_bur;
                  best_arr_in   = q_arr;
                  best_idx_in   = rd_idx_ff;
                  found_in      = 1'b1;
               end
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!found_ff) begin
               clock_in    = CLK_W'(next_arr_ff);
               state_in    = ST_SCAN;
               scan_cnt_in = '0;
               pend_in     = 1'b0;
            end else if (rsp_free) begin
               done_in[best_idx_ff] = 1'b1;
               clock_in             = end_full;
               finished_in          = finished_ff + CNT_W'(1);
               if (finished_in == job_count_ff) begin
                  state_in     = ST_LOAD;
                  job_count_in = '0;
                  clock_in     = '0;
                  dropped_in   = 1'b0;
                  done_in      = '0;
                  finished_in  = '0;
               end else begin
                  state_in    = ST_SCAN;
                  scan_cnt_in = '0;
                  found_in    = 1'b0;
                  pend_in     = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         job_count_ff <= '0;
         dropped_ff   <= 1'b0;
         clock_ff     <= '0;
         done_ff      <= '0;
         finished_ff  <= '0;
         scan_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_count_ff <= job_count_in;
         dropped_ff   <= dropped_in;
         clock_ff     <= clock_in;
         done_ff      <= done_in;
         finished_ff  <= finished_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_vld_ff    <= issue;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= scan_cnt_ff[IDX_W-1:0];
      best_burst_ff <= best_burst_in;
      best_arr_ff   <= best_arr_in;
      best_idx_ff   <= best_idx_in;
      next_arr_ff   <= next_arr_in;
      if (emit) begin
         rsp_index_ff <= JOB_INDEX_W'(best_idx_ff);
         rsp_start_ff <= OUT_TIME_W'(clock_ff);
         rsp_end_ff   <= OUT_TIME_W'(end_full);
         rsp_tat_ff   <= OUT_TIME_W'(tat_full);
         rsp_wait_ff  <= OUT_TIME_W'(wait_full);
         rsp_ovf_ff   <= dropped_ff;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.job_index     = rsp_index_ff;
   assign rsp_chan.start_time    = rsp_start_ff;
   assign rsp_chan.end_time      = rsp_end_ff;
   assign rsp_chan.turnaround    = rsp_tat_ff;
   assign rsp_chan.waiting       = rsp_wait_ff;
   assign rsp_chan.overflow_flag = rsp_ovf_ff;
   assign rsp_chan.last_result   = rsp_last_ff;

   a_done_within_count: assert property (@(posedge clock) disable iff (reset)
      $countones(done_ff) <= job_count_ff)
      else $error("more jobs marked finished than are stored");

   a_pending_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && !found_ff |-> pend_ff)
      else $error("no job eligible and none pending at a decision");

   a_pick_not_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && found_ff |-> !done_ff[best_idx_ff])
      else $error("a finished job was picked again");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      emit_last |=> (state_ff == ST_LOAD) && (job_count_ff == '0) && (done_ff == '0))
      else $error("set not cleared after its final transaction");

   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |=> (state_ff == ST_LOAD) || (clock_ff >= $past(clock_ff)))
      else $error("schedule clock moved backward");

endmodule

FILE: sim/tb_nonpreemptive_sjf_scheduler.sv
// Testbench for the shortest-job-first scheduler: directed and random job sets, predicted schedule, checks.
`timescale 1ns / 1ps

module tb_nonpreemptive_sjf_scheduler;
   import npsjf_pkg::*;

   typedef struct packed {
      logic [JOB_INDEX_W-1:0] job_index;
      logic [OUT_TIME_W-1:0]  start_time;
      logic [OUT_TIME_W-1:0]  end_time;
      logic [OUT_TIME_W-1:0]  turnaround;
      logic [OUT_TIME_W-1:0]  waiting;
      logic                   overflow_flag;
      logic                   last_result;
   } sched_result_type;

   class sjf_scoreboard;
      sched_result_type schedule_q[$];
      logic [IN_TIME_W-1:0] arrival_mem[MAX_JOBS];
      logic [IN_TIME_W-1:0] burst_mem[MAX_JOBS];
      int unsigned job_count;
      bit dropped;
      int unsigned checked;
      int unsigned errors;
      int unsigned sets_done;
      int unsigned overflow_sets;

      function new();
         job_count = 0;
         dropped = 0;
         checked = 0;
         errors = 0;
         sets_done = 0;
         overflow_sets = 0;
      endfunction

      function void note_job(logic [IN_TIME_W-1:0] arrival, logic [IN_TIME_W-1:0] burst,
                             logic last);
         bit done[MAX_JOBS];
         bit found;
         bit any_pending;
         int unsigned clock_tick;
         int unsigned finished;
         int unsigned pick;
         int unsigned best;
         int unsigned next_arrival;
         int unsigned finish_tick;
         sched_result_type r;
         if (job_count < MAX_JOBS) begin
            arrival_mem[job_count] = arrival;
            burst_mem[job_count] = burst;
            job_count++;
         end else begin
            dropped = 1;
         end
         if (!last) return;
         foreach (done[i]) done[i] = 0;
         clock_tick = 0;
         finished = 0;
         while (finished < job_count) begin
            found = 0;
            any_pending = 0;
            pick = 0;
            best = 0;
            next_arrival = 0;
            for (int i = 0; i < job_count; i++) begin
               if (!done[i]) begin
                  if (!any_pending || arrival_mem[i] < next_arrival) begin
                     next_arrival = arrival_mem[i];
                     any_pending = 1;
                  end
                  if (arrival_mem[i] <= clock_tick && (!found || burst_mem[i] < best)) begin
                     best = burst_mem[i];
                     pick = i;
                     found = 1;
                  end
               end
            end
            if (!found) begin
               clock_tick = next_arrival;
            end else begin
               finish_tick = clock_tick + burst_mem[pick];
               r.job_index = JOB_INDEX_W'(pick);
               r.start_time = OUT_TIME_W'(clock_tick);
               r.end_time = OUT_TIME_W'(finish_tick);
               r.turnaround = OUT_TIME_W'(finish_tick - arrival_mem[pick]);
               r.waiting = OUT_TIME_W'(clock_tick - arrival_mem[pick]);
               r.overflow_flag = dropped;
               done[pick] = 1;
               finished++;
               r.last_result = (finished == job_count);
               clock_tick = finish_tick;
               schedule_q.push_back(r);
            end
         end
         sets_done++;
         if (dropped) overflow_sets++;
         job_count = 0;
         dropped = 0;
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type want;
         if (schedule_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected result transaction: idx %0d start %0d end %0d",
                        got.job_index, got.start_time, got.end_time);
            return;
         end
         want = schedule_q.pop_front();
         checked++;
         if (got.job_index !== want.job_index || got.start_time !== want.start_time ||
             got.end_time !== want.end_time || got.turnaround !== want.turnaround ||
             got.waiting !== want.waiting || got.overflow_flag !== want.overflow_flag ||
             got.last_result !== want.last_result) begin
            errors++;
            if (errors <= 10) begin
               $display("Mismatch on result %0d: expected idx %0d start %0d end %0d tat %0d",
                        checked, want.job_index, want.start_time, want.end_time,
                        want.turnaround);
               $display("   wait %0d ovf %0b last %0b; got idx %0d start %0d end %0d tat %0d",
                        want.waiting, want.overflow_flag, want.last_result, got.job_index,
                        got.start_time, got.end_time, got.turnaround);
               $display("   wait %0d ovf %0b last %0b", got.waiting, got.overflow_flag,
                        got.last_result);
            end
         end
      endfunction
   endclass

   localparam int TOTAL_JOBS     = 420;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;

   logic clock = 1'b0;
   logic reset;

   npsjf_req_if req_if();
   npsjf_rsp_if rsp_if();

   nonpreemptive_sjf_scheduler DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   sjf_scoreboard sb = new();

   int unsigned jobs_sent = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_trigger = 0;
   int unsigned quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_job(logic [IN_TIME_W-1:0] arrival, logic [IN_TIME_W-1:0] burst,
                           logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.arrival_time <= arrival;
      req_if.burst_time <= burst;
      req_if.is_last <= last;
      do @(posedge clock); while (!req_if.ready);
      sb.note_job(arrival, burst, last);
      jobs_sent++;
   endtask

   function automatic logic [IN_TIME_W-1:0] pick_time(int unsigned mode);
      int unsigned r;
      r = $urandom_range(15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      case (mode)
         0: return IN_TIME_W'($urandom_range(0, 15));
         1: return IN_TIME_W'($urandom_range(0, 2047));
         default: return IN_TIME_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_random_set();
      int unsigned set_size;
      int unsigned arrival_mode;
      int unsigned burst_mode;
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) set_size = 1;
      else if (r < 70) set_size = $urandom_range(2, 8);
      else if (r < 85) set_size = $urandom_range(9, MAX_JOBS);
      else set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      arrival_mode = $urandom_range(2);
      burst_mode = $urandom_range(2);
      for (int i = 0; i < set_size; i++)
         send_job(pick_time(arrival_mode), pick_time(burst_mode), i == set_size - 1);
   endtask

   task automatic send_directed();
      send_job(16'd0, 16'd0, 1'b1);
      send_job(16'd5, 16'd7, 1'b0);
      send_job(16'd5, 16'd7, 1'b0);
      send_job(16'd0, 16'd7, 1'b1);
      send_job(16'd0, 16'd9, 1'b0);
      send_job(16'd1, 16'd3, 1'b0);
      send_job(16'd2, 16'd0, 1'b0);
      send_job(16'd300, 16'd1, 1'b1);
      for (int i = 0; i < MAX_JOBS; i++)
         send_job(i[0] ? 16'hFFFF : 16'h0000, 16'(i * 4369), 1'b0);
      send_job(16'd1234, 16'd1234, 1'b1);
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.arrival_time <= '0;
      req_if.burst_time <= '0;
      req_if.is_last <= 1'b0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
            3: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
               hold_trigger <= hold_trigger + 1;
            end
         endcase
         while (jobs_sent < 25 + (phase + 1) * (TOTAL_JOBS - 25) / 5)
            send_random_set();
      end
      req_if.valid <= 1'b0;

      while (sb.schedule_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Scheduled %0d job sets from %0d jobs (%0d sets with dropped jobs).",
               sb.sets_done, jobs_sent, sb.overflow_sets);
      $display("Checked %0d results across idle, stall and back-pressure phases, %0d errors.",
               sb.checked, sb.errors);
      if (sb.errors == 0 && sb.schedule_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      sched_result_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.job_index = rsp_if.job_index;
         got.start_time = rsp_if.start_time;
         got.end_time = rsp_if.end_time;
         got.turnaround = rsp_if.turnaround;
         got.waiting = rsp_if.waiting;
         got.overflow_flag = rsp_if.overflow_flag;
         got.last_result = rsp_if.last_result;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transaction", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
